[hdl/itb_pkg.sv]
// indexed timer bank package: sizes, action codes and shared types
// used by every module of the indexed timer bank; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package itb_pkg;

	// number of timers in the bank, 1 to 32
	localparam int NUM_TIMERS = 16;

	localparam int ADDR_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int PTR_W  = $clog2(NUM_TIMERS + 1);

	localparam int ACTION_W  = 3;
	localparam int TIDX_W    = 5;
	localparam int COUNT_W   = 15;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	// one more bit than the index so the bank size itself fits
	localparam logic [TIDX_W:0] IDX_LIMIT = (TIDX_W + 1)'(NUM_TIMERS);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [ACTION_W-1:0] ACT_TICK       = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_READ       = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_LOAD_START = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_CLEAR_RUN  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_STOP_CLEAR = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_STOP       = 3'd5;

	typedef struct packed {
		logic               run;
		logic [COUNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage
`default_nettype wire

[hdl/itb_mem.sv]
// timer state memory: one write and one registered read port per cycle
// per-entry valid bits make unwritten entries read as zero and stopped; uses itb_pkg
`timescale 1ns / 1ps
`default_nettype none
module itb_mem (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire itb_pkg::mem_req_t req,
	output itb_pkg::entry_t       rdata
);

	itb_pkg::entry_t                  mem [itb_pkg::NUM_TIMERS];
	logic [itb_pkg::NUM_TIMERS-1:0]   vld_q;
	itb_pkg::entry_t                  rd_q;
	logic                             rvld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem[req.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rvld_q <= vld_q[req.raddr];
			end
		end
	end

	assign rdata = rvld_q ? rd_q : '0;

endmodule
`default_nettype wire

[hdl/itb_tick_unit.sv]
// shared tick unit: clamp at the maximum, else count up when running
// one instance serves every timer in turn; uses itb_pkg
`timescale 1ns / 1ps
`default_nettype none
module itb_tick_unit (
	input  wire itb_pkg::entry_t             cur,
	input  wire logic [itb_pkg::COUNT_W-1:0] max_count,
	output itb_pkg::entry_t                  nxt
);

	always_comb begin
		nxt.run = cur.run;
		if (cur.count >= max_count) begin
			nxt.count = max_count;
		end else if (cur.run) begin
			nxt.count = cur.count + 1'b1;
		end else begin
			nxt.count = cur.count;
		end
	end

endmodule
`default_nettype wire

[hdl/indexed_timer_bank.sv]
// indexed timer bank top level: input register, sequencer and output register
// instantiates itb_mem and itb_tick_unit; uses itb_pkg
//
// usage
// - s_* carries command words in, m_* carries one result word out per command
// - cfg_we/cfg_wdata write max_count; write only while the bank is idle
// - action 0 (tick) walks every timer through the shared tick unit, one timer
//   per cycle with the read of the next timer overlapped with the write of the
//   current one
// - read, load and start, clear and run, stop and clear, stop touch one timer
//   with a read and, except for read, a write of the state memory; an index
//   at or above the bank size changes nothing for them and flags index_error
// - such a bad index or an unused action skips the memory
// - s_tready is high only in the idle state, so one word is in work at a time;
//   a finished result sits in the output register while the next word is taken
// - if m_tready is low the result holds; the sequencer waits in its last state
//   until the output register frees up
// - reset clears all counts and run flags (through memory valid bits, no
//   clearing pass), sets max_count to its maximum and empties the output
`timescale 1ns / 1ps
`default_nettype none
module indexed_timer_bank (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [itb_pkg::COUNT_W-1:0]       cfg_wdata,   // max_count
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// action [2:0], timer_index [7:3], load_count [22:8], zero [23]
	input  wire logic [itb_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// read_count [14:0], index_error [15]
	output logic [itb_pkg::M_TDATA_W-1:0]          m_tdata
);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CMD    = 3'd1;
	localparam logic [2:0] ST_CMD_WB = 3'd2;
	localparam logic [2:0] ST_TICK   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]                       state_q, state_nxt;
	logic [itb_pkg::COUNT_W-1:0]      max_count_q;

	// accepted command word
	logic [itb_pkg::ACTION_W-1:0]     act_q;
	logic [itb_pkg::TIDX_W-1:0]       idx_q;
	logic [itb_pkg::COUNT_W-1:0]      load_q;

	// tick sweep: read pointer and the write stage one entry behind
	logic [itb_pkg::PTR_W-1:0]        ptr_q;
	logic                             vld_s1;
	logic [itb_pkg::ADDR_W-1:0]       addr_s1;

	// pending result
	logic [itb_pkg::COUNT_W-1:0]      res_count_q;
	logic                             res_err_q;

	logic                             m_tvalid_q;
	logic [itb_pkg::M_TDATA_W-1:0]    m_tdata_q;

	itb_pkg::mem_req_t                mem_req;
	itb_pkg::entry_t                  mem_rdata;
	itb_pkg::entry_t                  tick_out;

	logic                             accept;
	logic                             cmd_ok;
	logic                             idx_ok;
	logic                             tick_rd;
	logic                             out_free;

	itb_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata)
	);

	// clamp / increment of the entry read last cycle
	itb_tick_unit u_tick (
		.cur       (mem_rdata),
		.max_count (max_count_q),
		.nxt       (tick_out)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign cmd_ok  = act_q inside {[itb_pkg::ACT_READ : itb_pkg::ACT_STOP]};
	assign idx_ok  = {1'b0, idx_q} < itb_pkg::IDX_LIMIT;
	assign tick_rd = (state_q == ST_TICK) &&
		(ptr_q < itb_pkg::PTR_W'(itb_pkg::NUM_TIMERS));

	// memory requests and next state
	always_comb begin
		mem_req   = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tdata[itb_pkg::ACTION_W-1:0] == itb_pkg::ACT_TICK) begin
						state_nxt = ST_TICK;
					end else begin
						state_nxt = ST_CMD;
					end
				end
			end
			ST_CMD: begin
				// every valid command reads its timer first; stop keeps the count
				if (cmd_ok && idx_ok) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = idx_q[itb_pkg::ADDR_W-1:0];
					state_nxt     = ST_CMD_WB;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_CMD_WB: begin
				mem_req.waddr = idx_q[itb_pkg::ADDR_W-1:0];
				case (act_q)
					itb_pkg::ACT_LOAD_START: begin
						mem_req.we    = 1'b1;
						mem_req.wdata = '{run: 1'b1, count: load_q};
					end
					itb_pkg::ACT_CLEAR_RUN: begin
						mem_req.we    = 1'b1;
						mem_req.wdata = '{run: 1'b1, count: '0};
					end
					itb_pkg::ACT_STOP_CLEAR: begin
						mem_req.we    = 1'b1;
						mem_req.wdata = '{run: 1'b0, count: '0};
					end
					itb_pkg::ACT_STOP: begin
						mem_req.we    = 1'b1;
						mem_req.wdata = '{run: 1'b0, count: mem_rdata.count};
					end
					default: begin
						mem_req.we = 1'b0;
					end
				endcase
				state_nxt = ST_DONE;
			end
			ST_TICK: begin
				// read entry ptr while writing back the entry before it
				mem_req.re    = tick_rd;
				mem_req.raddr = ptr_q[itb_pkg::ADDR_W-1:0];
				mem_req.we    = vld_s1;
				mem_req.waddr = addr_s1;
				mem_req.wdata = tick_out;
				if (!tick_rd) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_count_q <= itb_pkg::COUNT_MAX;
			ptr_q       <= '0;
			vld_s1      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				max_count_q <= cfg_wdata;
			end
			if (accept) begin
				ptr_q  <= '0;
				vld_s1 <= 1'b0;
			end else if (state_q == ST_TICK) begin
				vld_s1 <= tick_rd;
				if (tick_rd) begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q       <= s_tdata[itb_pkg::ACTION_W-1:0];
			idx_q       <= s_tdata[itb_pkg::ACTION_W +: itb_pkg::TIDX_W];
			load_q      <= s_tdata[itb_pkg::ACTION_W + itb_pkg::TIDX_W +: itb_pkg::COUNT_W];
			res_count_q <= '0;
			res_err_q   <= 1'b0;
		end
		if (state_q == ST_TICK) begin
			addr_s1 <= ptr_q[itb_pkg::ADDR_W-1:0];
		end
		if (state_q == ST_CMD) begin
			res_err_q <= cmd_ok && !idx_ok;
		end
		if ((state_q == ST_CMD_WB) && (act_q == itb_pkg::ACT_READ)) begin
			res_count_q <= mem_rdata.count;
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= {res_err_q, res_count_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

[hdl/itb_checker.sv]
// port-level checks for the indexed timer bank, bound to the top level
// uses itb_pkg for widths
`timescale 1ns / 1ps
`default_nettype none
module itb_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [itb_pkg::M_TDATA_W-1:0] m_tdata
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// a flagged index never carries a count
	a_err_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[itb_pkg::COUNT_W] |-> m_tdata[itb_pkg::COUNT_W-1:0] == '0)
		else $error("index error with nonzero count");

	// one word in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("word taken while previous one in work");

	// no new result appears right after a word is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (!m_tvalid || m_tready) |=> !m_tvalid)
		else $error("result appeared one cycle after accept");

endmodule

bind indexed_timer_bank itb_checker u_itb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
